### rtl/hep_pkg.sv
// ----------------------------------------------------------------------------
// Huffman encoder package
// Shared types and constants for the Huffman encoder and byte packer.
// ----------------------------------------------------------------------------
package hep_pkg;

  localparam int unsigned SYMBOL_COUNT = 256;
  localparam int unsigned SYM_W        = 8;
  localparam int unsigned CODE_W       = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned MAX_CODE_LEN = 32;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PEND_W       = BYTE_W - 1;
  localparam int unsigned WORK_W       = CODE_W + PEND_W;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_ENCODE = 2'd1,
    MODE_FLUSH  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_ENCODE  = 2'd0,
    CMD_FLUSH   = 2'd1,
    CMD_UNKNOWN = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;
    logic              unknown_symbol;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_entry_t;

  // Command handed from the front end to the packer. The code is left-aligned.
  typedef struct packed {
    cmd_kind_e         kind;
    logic [CODE_W-1:0] code_l;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

endpackage

### rtl/hep_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hep_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/hep_front.sv
// ----------------------------------------------------------------------------
// Huffman encoder front end
// Accepts items, owns the code table, and turns each encode or flush item
// into a command for the packer.
// ----------------------------------------------------------------------------
module hep_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  hep_pkg::in_item_t   in_item_i,
  input  hep_pkg::fifo_stat_t fifo_stat_i,
  output logic                cmd_push_o,
  output hep_pkg::cmd_t       cmd_o
);
  import hep_pkg::*;

  logic                    accept;
  logic [SYMBOL_COUNT-1:0] valid_q, valid_d;
  logic                    s1_vld_q, s1_vld_d;
  cmd_kind_e               s1_kind_q, s1_kind_d;
  logic                    tbl_we, tbl_re;
  tbl_entry_t              tbl_wdata, tbl_rdata;
  logic [LEN_W-1:0]        clamp_len;
  logic [LEN_W-1:0]        shamt;
  logic [FIFO_CW-1:0]      inflight;

  // The stage register always drains into the queue, so it counts as occupied.
  assign inflight = fifo_stat_i.count + FIFO_CW'(s1_vld_q);
  assign full     = (inflight >= FIFO_CW'(FIFO_DEPTH));
  assign accept   = push && !full;

  assign clamp_len = (in_item_i.code_length > LEN_W'(MAX_CODE_LEN)) ?
                     LEN_W'(MAX_CODE_LEN) : in_item_i.code_length;

  always_comb begin
    valid_d        = valid_q;
    s1_vld_d       = 1'b0;
    s1_kind_d      = s1_kind_q;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;
    tbl_wdata.len  = clamp_len;
    tbl_wdata.code = in_item_i.code_word;
    if (accept) begin
      case (in_item_i.mode)
        MODE_LOAD: begin
          tbl_we                     = 1'b1;
          valid_d[in_item_i.symbol] = 1'b1;
        end
        MODE_ENCODE: begin
          tbl_re    = 1'b1;
          s1_vld_d  = 1'b1;
          s1_kind_d = valid_q[in_item_i.symbol] ? CMD_ENCODE : CMD_UNKNOWN;
        end
        MODE_FLUSH: begin
          s1_vld_d  = 1'b1;
          s1_kind_d = CMD_FLUSH;
        end
        default: begin
        end
      endcase
    end
  end

  hep_ram #(
    .Width($bits(tbl_entry_t)),
    .Depth(SYMBOL_COUNT)
  ) u_tbl (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(in_item_i.symbol),
    .wdata_i(tbl_wdata),
    .re_i   (tbl_re),
    .raddr_i(in_item_i.symbol),
    .rdata_o(tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      s1_vld_q  <= 1'b0;
      s1_kind_q <= CMD_FLUSH;
    end else begin
      valid_q   <= valid_d;
      s1_vld_q  <= s1_vld_d;
      s1_kind_q <= s1_kind_d;
    end
  end

  // Left-align the code word so that its first bit sits in the top position;
  // bits above the code length fall off the top.
  assign shamt        = LEN_W'(CODE_W) - tbl_rdata.len;
  assign cmd_push_o   = s1_vld_q;
  assign cmd_o.kind   = s1_kind_q;
  assign cmd_o.len    = (s1_kind_q == CMD_ENCODE) ? tbl_rdata.len : '0;
  assign cmd_o.code_l = tbl_rdata.code << shamt;

endmodule

### rtl/hep_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Short queue of packer commands between the front end and the packer.
// ----------------------------------------------------------------------------
module hep_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hep_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output hep_pkg::cmd_t       cmd_o,
  output hep_pkg::fifo_stat_t stat_o
);
  import hep_pkg::*;

  cmd_t               slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d;
  logic [FIFO_AW-1:0] rptr_q, rptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;
  logic               do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = rptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

  assign cmd_o        = slot_q[rptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

### rtl/hep_packer.sv
// ----------------------------------------------------------------------------
// Byte packer
// Appends code bits to pending bits, handing out one byte per cycle when popped.
// ----------------------------------------------------------------------------
module hep_packer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hep_pkg::cmd_t       cmd_i,
  input  logic                cmd_empty_i,
  output logic                cmd_pop_o,
  output logic                empty,
  input  logic                pop,
  output hep_pkg::out_item_t  out_item_o
);
  import hep_pkg::*;

  // The work register holds its bits left-aligned with zeros below them.
  logic [WORK_W-1:0] work_q, work_d;
  logic [LEN_W-1:0]  wcnt_q, wcnt_d;
  logic              out_vld_q, out_vld_d;
  out_item_t         out_q, out_d;
  logic              can_out, emit, take;
  logic [WORK_W-1:0] rem_bits;
  logic [LEN_W-1:0]  rem_cnt;

  assign can_out  = !out_vld_q || pop;
  assign emit     = (wcnt_q >= LEN_W'(BYTE_W)) && can_out;
  assign rem_bits = emit ? (work_q << BYTE_W) : work_q;
  assign rem_cnt  = emit ? (wcnt_q - LEN_W'(BYTE_W)) : wcnt_q;

  // An unknown symbol writes its result directly, so it needs a free slot.
  always_comb begin
    take = !cmd_empty_i && (rem_cnt < LEN_W'(BYTE_W));
    if (cmd_i.kind == CMD_UNKNOWN) begin
      take = take && can_out && !emit;
    end
  end

  always_comb begin
    work_d    = rem_bits;
    wcnt_d    = rem_cnt;
    out_vld_d = out_vld_q && !pop;
    out_d     = out_q;
    if (emit) begin
      out_vld_d            = 1'b1;
      out_d.packed_byte    = work_q[WORK_W-1 -: BYTE_W];
      out_d.last_of_run    = (wcnt_q < LEN_W'(2 * BYTE_W));
      out_d.unknown_symbol = 1'b0;
    end
    if (take) begin
      case (cmd_i.kind)
        CMD_ENCODE: begin
          work_d = rem_bits | ({cmd_i.code_l, PEND_W'(0)} >> rem_cnt[2:0]);
          wcnt_d = rem_cnt + cmd_i.len;
        end
        CMD_FLUSH: begin
          // The pad bits are already zero, so a flush just closes the byte.
          wcnt_d = (rem_cnt == '0) ? '0 : LEN_W'(BYTE_W);
        end
        CMD_UNKNOWN: begin
          out_vld_d            = 1'b1;
          out_d.packed_byte    = '0;
          out_d.last_of_run    = 1'b1;
          out_d.unknown_symbol = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q    <= '0;
      wcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      work_q    <= work_d;
      wcnt_q    <= wcnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign cmd_pop_o  = take;
  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

endmodule

### rtl/huffman_encode_bit_packer.sv
// ----------------------------------------------------------------------------
// Huffman encoder with byte packer
// Loadable code table feeding an MSB-first byte packer.
// ----------------------------------------------------------------------------
// The block accepts one item per cycle while full is low. A load writes the
// code table and gives no result; an encode gives one byte for every eight
// code bits that complete, and a flush gives the zero-padded partial byte.
// Encodes and flushes pass a table read stage and a four-entry command
// queue; the packer then gathers code bits in its work register before a
// byte reaches the output register, while an encode of an unknown symbol
// skips the bit accumulator. Results leave through a single output register
// at one byte per cycle while pop is high, which sets the sustained rate:
// the packer takes no new command while a further whole byte is pending,
// and full rises when the queue cannot take more. The valid bits of the
// table are cleared by reset at once; no clearing pass is needed.
module huffman_encode_bit_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  hep_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output hep_pkg::out_item_t out_item_o
);
  import hep_pkg::*;

  logic       cmd_push, cmd_pop;
  cmd_t       cmd_in, cmd_out;
  fifo_stat_t fifo_stat;

  hep_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .fifo_stat_i(fifo_stat),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  hep_cmd_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(cmd_push),
    .cmd_i (cmd_in),
    .pop_i (cmd_pop),
    .cmd_o (cmd_out),
    .stat_o(fifo_stat)
  );

  hep_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_out),
    .cmd_empty_i(fifo_stat.empty),
    .cmd_pop_o  (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

### rtl/hep_checker.sv
// ----------------------------------------------------------------------------
// Huffman encoder port checker
// Checks the behavior seen on the ports of the top level over time.
// ----------------------------------------------------------------------------
module hep_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input hep_pkg::in_item_t  in_item_i,
  input logic               empty,
  input logic               pop,
  input hep_pkg::out_item_t out_item_o
);
  import hep_pkg::*;

  // In the cycle after reset is seen low, nothing is waiting and the input is open.
  a_reset_state: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("outputs not idle during reset");

  // A waiting item that is not taken stays on the ports unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting item changed before it was taken");

  // An unknown symbol gives a single zero byte that closes its run.
  a_unknown_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.unknown_symbol) |->
      (out_item_o.last_of_run && (out_item_o.packed_byte == '0)))
    else $error("malformed unknown symbol item");

  // A load accepted into an idle block gives no item.
  a_idle_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && (in_item_i.mode == MODE_LOAD) && empty && $past(empty)
     && $past(empty, 2) && $past(empty, 3) && $past(!push, 1) && $past(!push, 2)
     && $past(!push, 3) && $past(!push, 4) && $past(!push, 5))
      |=> empty)
    else $error("load produced an item");

endmodule

bind huffman_encode_bit_packer hep_checker u_hep_checker (.*);

### bench/tb.sv
// ----------------------------------------------------------------------------
// Huffman encoder byte packer testbench
// Drives load, encode and flush items through the push/full side and checks
// every packed byte popped from the result side against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hep_pkg::*;

  // Mode 3 has no meaning; the block must drop such an item.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      push    = 1'b0;
  logic      pop     = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_item = '0;
  out_item_t out_item;

  // Local model state: code table and the partial byte.
  logic [CODE_W-1:0] code_mem  [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem   [SYMBOL_COUNT];
  logic              entry_loaded [SYMBOL_COUNT];
  logic [PEND_W-1:0] pend_bits  = '0;
  int unsigned       pend_count = 0;

  out_item_t   expected_bytes [$];
  logic [7:0]  loaded_syms [$];
  logic        no_gaps   = 1'b0;
  int unsigned err_count = 0;

  huffman_encode_bit_packer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic in_item_t make_item(input logic [1:0] mode, input logic [7:0] sym,
                                         input logic [CODE_W-1:0] word,
                                         input logic [LEN_W-1:0] len);
    in_item_t it;
    it.mode        = mode;
    it.symbol      = sym;
    it.code_word   = word;
    it.code_length = len;
    return it;
  endfunction

  // Works out the bytes an accepted item produces and queues them in order.
  function automatic void predict_packed_bytes(input in_item_t it);
    out_item_t   run [$];
    out_item_t   r;
    logic [7:0]  acc;
    int unsigned cnt;
    int unsigned clen;
    case (it.mode)
      MODE_LOAD: begin
        if (!entry_loaded[it.symbol]) loaded_syms = {loaded_syms, it.symbol};
        code_mem[it.symbol]     = it.code_word;
        len_mem[it.symbol]      = (it.code_length > MAX_CODE_LEN) ?
                                  LEN_W'(MAX_CODE_LEN) : it.code_length;
        entry_loaded[it.symbol] = 1'b1;
      end
      MODE_ENCODE: begin
        if (!entry_loaded[it.symbol]) begin
          r.packed_byte    = '0;
          r.last_of_run    = 1'b1;
          r.unknown_symbol = 1'b1;
          expected_bytes   = {expected_bytes, r};
        end else begin
          acc  = {1'b0, pend_bits};
          cnt  = pend_count;
          clen = len_mem[it.symbol];
          for (int unsigned i = clen; i > 0; i--) begin
            acc = {acc[6:0], code_mem[it.symbol][i-1]};
            cnt++;
            if (cnt == 8) begin
              r.packed_byte    = acc;
              r.last_of_run    = 1'b0;
              r.unknown_symbol = 1'b0;
              run = {run, r};
              acc = '0;
              cnt = 0;
            end
          end
          pend_bits  = acc[6:0];
          pend_count = cnt;
          if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
          foreach (run[k]) expected_bytes = {expected_bytes, run[k]};
        end
      end
      MODE_FLUSH: begin
        if (pend_count != 0) begin
          acc              = {1'b0, pend_bits};
          r.packed_byte    = acc << (8 - pend_count);
          r.last_of_run    = 1'b1;
          r.unknown_symbol = 1'b0;
          expected_bytes   = {expected_bytes, r};
          pend_bits  = '0;
          pend_count = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Leaves push high on return so that back-to-back items need no extra edge.
  task automatic send_item(input in_item_t it);
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 38) begin
        push <= 1'b0;
        @(posedge clk_i);
      end
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_packed_bytes(it);
  endtask

  task automatic wait_for_results;
    push <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  // Result side: compare each popped byte with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_item));
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.packed_byte !== want.packed_byte)
          report_mismatch($sformatf("packed_byte %h, expected %h",
                                    out_item.packed_byte, want.packed_byte));
        if (out_item.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run %b, expected %b",
                                    out_item.last_of_run, want.last_of_run));
        if (out_item.unknown_symbol !== want.unknown_symbol)
          report_mismatch($sformatf("unknown_symbol %b, expected %b",
                                    out_item.unknown_symbol, want.unknown_symbol));
      end
    end
    pop <= no_gaps || ($urandom_range(0, 99) >= 38);
  end

  // Unknown symbols, an empty flush and the unused mode straight after reset.
  task automatic test_after_reset;
    send_item(make_item(MODE_ENCODE, 8'h00, '0, '0));
    send_item(make_item(MODE_ENCODE, 8'hFF, '0, '0));
    send_item(make_item(MODE_FLUSH, 8'h00, '0, '0));
    send_item(make_item(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
  endtask

  task automatic test_directed_codes;
    // A zero-length code adds nothing.
    send_item(make_item(MODE_LOAD, 8'h00, 32'h0, 6'd0));
    send_item(make_item(MODE_ENCODE, 8'h00, '0, '0));
    send_item(make_item(MODE_LOAD, 8'h01, 32'h1, 6'd1));
    send_item(make_item(MODE_ENCODE, 8'h01, '0, '0));
    send_item(make_item(MODE_FLUSH, 8'h00, '0, '0));
    // An overlong length is clamped, so this gives four bytes of ones.
    send_item(make_item(MODE_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    send_item(make_item(MODE_ENCODE, 8'hFF, '0, '0));
    send_item(make_item(MODE_LOAD, 8'h80, 32'h0000_00A5, 6'd8));
    send_item(make_item(MODE_ENCODE, 8'h80, '0, '0));
    send_item(make_item(MODE_LOAD, 8'h7F, 32'h8000_0001, 6'd32));
    send_item(make_item(MODE_ENCODE, 8'h01, '0, '0));
    send_item(make_item(MODE_ENCODE, 8'h7F, '0, '0));
    send_item(make_item(MODE_FLUSH, 8'h00, '0, '0));
    send_item(make_item(MODE_LOAD, 8'h55, 32'h0000_005A, 6'd7));
    send_item(make_item(MODE_ENCODE, 8'h55, '0, '0));
    // An unknown symbol leaves the seven pending bits alone.
    send_item(make_item(MODE_ENCODE, 8'h33, '0, '0));
    send_item(make_item(MODE_ENCODE, 8'h01, '0, '0));
    send_item(make_item(MODE_FLUSH, 8'h00, '0, '0));
    send_item(make_item(MODE_LOAD, 8'h2A, 32'h5555_5557, 6'd2));
    send_item(make_item(MODE_ENCODE, 8'h2A, '0, '0));
    send_item(make_item(MODE_ENCODE, 8'h2A, '0, '0));
    send_item(make_item(MODE_ENCODE, 8'h2A, '0, '0));
    send_item(make_item(MODE_FLUSH, 8'h00, '0, '0));
  endtask

  task automatic run_random_stream(input int unsigned n_items);
    int unsigned       pick;
    int unsigned       lsel;
    logic [LEN_W-1:0]  len;
    logic [7:0]        sym;
    in_item_t          it;
    for (int unsigned n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 || loaded_syms.size() == 0) begin
        lsel = $urandom_range(0, 99);
        if (lsel < 5)       len = '0;
        else if (lsel < 70) len = LEN_W'($urandom_range(1, 12));
        else if (lsel < 92) len = LEN_W'($urandom_range(13, 32));
        else                len = LEN_W'($urandom_range(33, 63));
        it = make_item(MODE_LOAD, 8'($urandom()), $urandom(), len);
      end else if (pick < 85) begin
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        it  = make_item(MODE_ENCODE, sym, $urandom(), LEN_W'($urandom()));
      end else if (pick < 90) begin
        it = make_item(MODE_ENCODE, 8'($urandom()), $urandom(), LEN_W'($urandom()));
      end else if (pick < 97) begin
        it = make_item(MODE_FLUSH, 8'($urandom()), $urandom(), LEN_W'($urandom()));
      end else begin
        it = make_item(MODE_UNUSED, 8'($urandom()), $urandom(), LEN_W'($urandom()));
      end
      send_item(it);
    end
  endtask

  task automatic test_random_mix;
    run_random_stream(280);
  endtask

  // Both sides run without any idle cycles here.
  task automatic test_full_rate;
    no_gaps = 1'b1;
    run_random_stream(90);
    no_gaps = 1'b0;
  endtask

  task automatic test_after_drain;
    wait_for_results();
    run_random_stream(75);
  endtask

  initial begin
    foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_directed_codes();
    test_random_mix();
    test_full_rate();
    test_after_drain();
    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### huffman_encode_bit_packer.f
rtl/hep_pkg.sv
rtl/hep_ram.sv
rtl/hep_front.sv
rtl/hep_cmd_fifo.sv
rtl/hep_packer.sv
rtl/huffman_encode_bit_packer.sv
rtl/hep_checker.sv
bench/tb.sv
